/* hw/rtl/prr_pkg.sv */
// Shared constants for the pseudorange residual and line-of-sight block.
`timescale 1ns / 1ps
package prr_pkg;
    localparam int COORD_WIDTH_DEF   = 41;  // coordinate width, 0.1 mm units
    localparam int DIR_FRAC_BITS_DEF = 30;  // fraction bits of the direction cosines
    localparam int NUM_AXES          = 3;   // x, y, z lanes
endpackage

/* hw/rtl/prr_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
module prr_sqrt #(
    parameter int N_W  = 86,
    parameter int SB_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [N_W-1:0]    i_n,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_vld,
    output logic [N_W/2-1:0]  o_root,
    output logic [N_W/2+1:0]  o_rem,
    output logic [SB_W-1:0]   o_sb
);
    localparam int RW    = N_W / 2;
    localparam int STEPS = RW;

    logic [STEPS-1:0] r_vld;
    logic [RW+1:0]    r_rem  [STEPS];
    logic [RW-1:0]    r_root [STEPS];
    logic [N_W-1:0]   r_n    [STEPS];
    logic [SB_W-1:0]  r_sb   [STEPS];

    logic [STEPS-1:0] in_vld;
    logic [RW+1:0]    in_rem  [STEPS];
    logic [RW-1:0]    in_root [STEPS];
    logic [N_W-1:0]   in_n    [STEPS];
    logic [SB_W-1:0]  in_sb   [STEPS];
    logic [RW+3:0]    cur     [STEPS];
    logic [RW+3:0]    trial   [STEPS];
    logic [RW+3:0]    dif     [STEPS];
    logic [STEPS-1:0] ge;

    always_comb begin
        in_vld[0]  = i_vld;
        in_rem[0]  = '0;
        in_root[0] = '0;
        in_n[0]    = i_n;
        in_sb[0]   = i_sb;
        for (int s = 1; s < STEPS; s++) begin
            in_vld[s]  = r_vld[s-1];
            in_rem[s]  = r_rem[s-1];
            in_root[s] = r_root[s-1];
            in_n[s]    = r_n[s-1];
            in_sb[s]   = r_sb[s-1];
        end
        // bring down the next two radicand bits, try root*4+1
        for (int s = 0; s < STEPS; s++) begin
            cur[s]   = {in_rem[s], in_n[s][N_W-1 -: 2]};
            trial[s] = {2'b00, in_root[s], 2'b01};
            ge[s]    = (cur[s] >= trial[s]);
            dif[s]   = cur[s] - trial[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STEPS; s++) begin
                r_rem[s]  <= ge[s] ? dif[s][RW+1:0] : cur[s][RW+1:0];
                r_root[s] <= {in_root[s][RW-2:0], ge[s]};
                r_n[s]    <= {in_n[s][N_W-3:0], 2'b00};
                r_sb[s]   <= in_sb[s];
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_root[STEPS-1];
    assign o_rem  = r_rem[STEPS-1];
    assign o_sb   = r_sb[STEPS-1];
endmodule

/* hw/rtl/prr_div.sv */
// Pipelined restoring divider, shared divisor over several lanes, one quotient bit per stage.
`timescale 1ns / 1ps
module prr_div #(
    parameter int D_W   = 44,
    parameter int Q_W   = 31,
    parameter int LANES = 3,
    parameter int SB_W  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [LANES-1:0][D_W-1:0]   i_num,
    input  logic [D_W-1:0]              i_den,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_vld,
    output logic [LANES-1:0][Q_W-1:0]   o_q,
    output logic [LANES-1:0][D_W-1:0]   o_rem,
    output logic [D_W-1:0]              o_den,
    output logic [SB_W-1:0]             o_sb
);
    localparam int STEPS = Q_W;

    logic [Q_W-1:0]                 r_vld;
    logic [LANES-1:0][D_W-1:0]      r_rem [STEPS];
    logic [LANES-1:0][Q_W-1:0]      r_q   [STEPS];
    logic [D_W-1:0]                 r_den [STEPS];
    logic [SB_W-1:0]                r_sb  [STEPS];

    logic [STEPS-1:0]               in_vld;
    logic [LANES-1:0][Q_W-1:0]      in_q   [STEPS];
    logic [D_W-1:0]                 in_den [STEPS];
    logic [SB_W-1:0]                in_sb  [STEPS];
    logic [LANES-1:0][D_W:0]        cur    [STEPS];
    logic [LANES-1:0][D_W:0]        dif    [STEPS];
    logic [LANES-1:0]               ge     [STEPS];

    always_comb begin
        in_vld[0] = i_vld;
        in_q[0]   = '0;
        in_den[0] = i_den;
        in_sb[0]  = i_sb;
        for (int l = 0; l < LANES; l++) begin
            cur[0][l] = {1'b0, i_num[l]};
        end
        for (int s = 1; s < STEPS; s++) begin
            in_vld[s] = r_vld[s-1];
            in_q[s]   = r_q[s-1];
            in_den[s] = r_den[s-1];
            in_sb[s]  = r_sb[s-1];
            for (int l = 0; l < LANES; l++) begin
                cur[s][l] = {r_rem[s-1][l], 1'b0};
            end
        end
        for (int s = 0; s < STEPS; s++) begin
            for (int l = 0; l < LANES; l++) begin
                ge[s][l]  = (cur[s][l] >= {1'b0, in_den[s]});
                dif[s][l] = cur[s][l] - {1'b0, in_den[s]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STEPS; s++) begin
                r_den[s] <= in_den[s];
                r_sb[s]  <= in_sb[s];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= ge[s][l] ? dif[s][l][D_W-1:0] : cur[s][l][D_W-1:0];
                    r_q[s][l]   <= {in_q[s][l][Q_W-2:0], ge[s][l]};
                end
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_q   = r_q[STEPS-1];
    assign o_rem = r_rem[STEPS-1];
    assign o_den = r_den[STEPS-1];
    assign o_sb  = r_sb[STEPS-1];
endmodule

/* hw/rtl/pseudorange_residual_and_jacobian.sv */
// Top level: pseudorange residual and negated line-of-sight unit vector per satellite.
// Throughput: one transfer per cycle while the output is not stalled; the root takes one bit
//   per stage and the divider one quotient bit per stage, so both are fully pipelined.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears every valid bit; payload registers are not reset.
`timescale 1ns / 1ps
module pseudorange_residual_and_jacobian import prr_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata, low bit up: sat_x, sat_y, sat_z, rx_x, rx_y, rx_z, clock_offset, observed_range
    input  logic [((8*COORD_WIDTH-1+7)/8)*8-1:0] i_s_tdata,
    // master side
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata, low bit up: residual, dir_x, dir_y, dir_z
    output logic [((COORD_WIDTH+3*(DIR_FRAC_BITS+2)+7)/8)*8-1:0] o_m_tdata,
    // tuser, low bit up: zero_distance, saturated
    output logic [1:0] o_m_tuser
);
    localparam int W      = COORD_WIDTH;
    localparam int F      = DIR_FRAC_BITS;
    localparam int DIR_W  = F + 2;
    localparam int MW     = W + 1;            // magnitude of a coordinate difference
    localparam int HW     = (MW + 1) / 2;     // half width for partial products
    localparam int SQ_W   = 2 * MW;
    localparam int SW     = 2 * MW + 2;       // sum of three squares, even width
    localparam int RW     = SW / 2;           // floor root width
    localparam int DW     = RW + 1;           // rounded distance width
    localparam int OD_W   = ((W + 3*DIR_W + 7) / 8) * 8;
    localparam int SQ_SB  = (W + 1) + NUM_AXES + NUM_AXES*MW;
    localparam int DV_SB  = W + 2 + NUM_AXES;

    // Global advance: the pipeline moves when the output register is free or being taken.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---- Stage A: differences, magnitudes, clock offset minus range ----
    logic [NUM_AXES-1:0][W-1:0] in_sat, in_rx;
    logic [W-1:0]               in_ofs;
    logic [W-2:0]               in_rng;
    logic [NUM_AXES-1:0][W:0]   a_diff;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            in_sat[k] = i_s_tdata[k*W +: W];
            in_rx[k]  = i_s_tdata[(NUM_AXES+k)*W +: W];
            a_diff[k] = {in_sat[k][W-1], in_sat[k]} - {in_rx[k][W-1], in_rx[k]};
        end
        in_ofs = i_s_tdata[2*NUM_AXES*W +: W];
        in_rng = i_s_tdata[(2*NUM_AXES+1)*W +: (W-1)];
    end

    logic                        r_a_vld;
    logic [NUM_AXES-1:0][MW-1:0] r_a_mag;
    logic [NUM_AXES-1:0]         r_a_neg;
    logic [W:0]                  r_a_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_a_neg[k] <= a_diff[k][W];
                r_a_mag[k] <= a_diff[k][W] ? (~a_diff[k] + 1'b1) : a_diff[k];
            end
            r_a_ofs <= {in_ofs[W-1], in_ofs} - {2'b00, in_rng};
        end
    end

    // ---- Stage B: partial products of each square ----
    logic [NUM_AXES-1:0][2*HW-1:0] b_ext;
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            b_ext[k] = {{(2*HW-MW){1'b0}}, r_a_mag[k]};
        end
    end

    logic                          r_b_vld;
    logic [NUM_AXES-1:0][2*HW-1:0] r_b_ll, r_b_lh, r_b_hh;
    logic [NUM_AXES-1:0][MW-1:0]   r_b_mag;
    logic [NUM_AXES-1:0]           r_b_neg;
    logic [W:0]                    r_b_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_b_ll[k] <= b_ext[k][HW-1:0] * b_ext[k][HW-1:0];
                r_b_lh[k] <= b_ext[k][HW-1:0] * b_ext[k][2*HW-1:HW];
                r_b_hh[k] <= b_ext[k][2*HW-1:HW] * b_ext[k][2*HW-1:HW];
            end
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            r_b_ofs <= r_a_ofs;
        end
    end

    // ---- Stage C: assemble squares ----
    logic [NUM_AXES-1:0][4*HW-1:0] c_sq;
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            c_sq[k] = ({{(2*HW){1'b0}}, r_b_hh[k]} << (2*HW))
                    + ({{(2*HW){1'b0}}, r_b_lh[k]} << (HW+1))
                    + {{(2*HW){1'b0}}, r_b_ll[k]};
        end
    end

    logic                          r_c_vld;
    logic [NUM_AXES-1:0][SQ_W-1:0] r_c_sq;
    logic [NUM_AXES-1:0][MW-1:0]   r_c_mag;
    logic [NUM_AXES-1:0]           r_c_neg;
    logic [W:0]                    r_c_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_c_sq[k] <= c_sq[k][SQ_W-1:0];
            end
            r_c_mag <= r_b_mag;
            r_c_neg <= r_b_neg;
            r_c_ofs <= r_b_ofs;
        end
    end

    // ---- Stage D: sum of squares ----
    logic          r_d_vld;
    logic [SW-1:0] r_d_sum;
    logic [SQ_SB-1:0] r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sum <= {2'b00, r_c_sq[0]} + {2'b00, r_c_sq[1]} + {2'b00, r_c_sq[2]};
            r_d_sb  <= {r_c_ofs, r_c_neg, r_c_mag};
        end
    end

    // ---- Square root pipeline ----
    logic             sq_vld;
    logic [RW-1:0]    sq_root;
    logic [RW+1:0]    sq_rem;
    logic [SQ_SB-1:0] sq_sb;

    prr_sqrt #(
        .N_W  (SW),
        .SB_W (SQ_SB)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d_vld),
        .i_n     (r_d_sum),
        .i_sb    (r_d_sb),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_rem   (sq_rem),
        .o_sb    (sq_sb)
    );

    // ---- Stage E: round distance, residual with saturation ----
    logic [NUM_AXES-1:0][MW-1:0] e_mag;
    logic [NUM_AXES-1:0]         e_neg;
    logic [W:0]                  e_ofs;
    logic [DW-1:0]               e_dist;
    logic [W+3:0]                e_res;
    logic                        e_ovf;
    logic [W-1:0]                e_res_sat;

    always_comb begin
        {e_ofs, e_neg, e_mag} = sq_sb;
        // round to nearest: step up when the remainder exceeds the floor root
        e_dist = {1'b0, sq_root} + {{(DW-1){1'b0}}, (sq_rem > {2'b00, sq_root})};
        e_res  = {{(W+4-DW){1'b0}}, e_dist} + {{3{e_ofs[W]}}, e_ofs};
        e_ovf  = !((&e_res[W+3:W-1]) || !(|e_res[W+3:W-1]));
        if (e_ovf) begin
            e_res_sat = e_res[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            e_res_sat = e_res[W-1:0];
        end
    end

    logic                        r_e_vld;
    logic [NUM_AXES-1:0][DW-1:0] r_e_num;
    logic [DW-1:0]               r_e_dist;
    logic [DV_SB-1:0]            r_e_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_e_num[k] <= {{(DW-MW){1'b0}}, e_mag[k]};
            end
            r_e_dist <= e_dist;
            r_e_sb   <= {e_res_sat, e_ovf, (e_dist == '0), e_neg};
        end
    end

    // ---- Direction divider ----
    logic                         dv_vld;
    logic [NUM_AXES-1:0][F:0]     dv_q;
    logic [NUM_AXES-1:0][DW-1:0]  dv_rem;
    logic [DW-1:0]                dv_den;
    logic [DV_SB-1:0]             dv_sb;

    prr_div #(
        .D_W   (DW),
        .Q_W   (F + 1),
        .LANES (NUM_AXES),
        .SB_W  (DV_SB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_dist),
        .i_sb    (r_e_sb),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_rem   (dv_rem),
        .o_den   (dv_den),
        .o_sb    (dv_sb)
    );

    // ---- Output stage: round quotient, apply sign, mask on coincidence ----
    logic [W-1:0]                   f_res;
    logic                           f_sat;
    logic                           f_zero;
    logic [NUM_AXES-1:0]            f_neg;
    logic [NUM_AXES-1:0][DIR_W-1:0] f_qr;
    logic [NUM_AXES-1:0][DIR_W-1:0] f_dir;

    always_comb begin
        {f_res, f_sat, f_zero, f_neg} = dv_sb;
        for (int k = 0; k < NUM_AXES; k++) begin
            // round half away from zero: twice the remainder against the divisor
            f_qr[k] = {1'b0, dv_q[k]}
                    + {{(DIR_W-1){1'b0}}, ({dv_rem[k], 1'b0} >= {1'b0, dv_den})};
            if (f_zero) begin
                f_dir[k] = '0;
            end else if (f_neg[k]) begin
                f_dir[k] = f_qr[k];
            end else begin
                f_dir[k] = ~f_qr[k] + 1'b1;
            end
        end
    end

    logic                           r_o_vld;
    logic [W-1:0]                   r_o_res;
    logic [NUM_AXES-1:0][DIR_W-1:0] r_o_dir;
    logic                           r_o_zero;
    logic                           r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res  <= f_res;
            r_o_dir  <= f_dir;
            r_o_zero <= f_zero;
            r_o_sat  <= f_sat;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {{(OD_W - W - NUM_AXES*DIR_W){1'b0}}, r_o_dir, r_o_res};
    assign o_m_tuser  = {r_o_sat, r_o_zero};

    // ---- Checks ----
    // coincident positions give no direction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_zero |-> (r_o_dir == '0))
        else $error("direction nonzero at zero distance");

    // a clipped residual sits at one end of its range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_sat |->
            (r_o_res == {1'b1, {(W-1){1'b0}}}) || (r_o_res == {1'b0, {(W-1){1'b1}}}))
        else $error("saturated residual not at range limit");

    // direction magnitude never exceeds 1.0
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_dir[0][DIR_W-1] == r_o_dir[0][DIR_W-2] || r_o_dir[0][F-1:0] == '0)
                 && (r_o_dir[1][DIR_W-1] == r_o_dir[1][DIR_W-2] || r_o_dir[1][F-1:0] == '0)
                 && (r_o_dir[2][DIR_W-1] == r_o_dir[2][DIR_W-2] || r_o_dir[2][F-1:0] == '0))
        else $error("direction magnitude above one");

    // while the output is held, the valid bits of stages D and E stay as they are
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_e_vld) && $stable(r_d_vld))
        else $error("pipeline moved during stall");
endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for the pseudorange residual and line-of-sight block.
`timescale 1ns / 1ps
module testbench;
    import prr_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = DIR_FRAC_BITS_DEF;
    localparam int DW = FB + 2;
    localparam int SW = ((8*CW-1+7)/8)*8;
    localparam int MW = ((CW+3*DW+7)/8)*8;
    localparam int LATENCY = CW + FB + 9;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_LEN = 400;

    typedef struct packed {
        logic [CW-1:0] residual;
        logic [DW-1:0] dir_x;
        logic [DW-1:0] dir_y;
        logic [DW-1:0] dir_z;
        logic          zero_distance;
        logic          saturated;
    } t_los_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [SW-1:0]   i_s_tdata;   // sat_x, sat_y, sat_z, rx_x, rx_y, rx_z, clock_offset, range
    logic            o_m_tvalid;
    logic            i_m_tready;
    logic [MW-1:0]   o_m_tdata;   // residual, dir_x, dir_y, dir_z
    logic [1:0]      o_m_tuser;   // zero_distance, saturated

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    bit stim_done = 0;
    int idle_cycles = 0;

    pseudorange_residual_and_jacobian u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Predicts the residual and Jacobian row of each transfer and checks results in order.
    class t_los_scoreboard;
        t_los_row pending[$];

        // nearest-integer square root of a sum of three squares
        function automatic logic [63:0] round_root(input logic [127:0] n);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] rem;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if ({64'd0, c} * {64'd0, c} <= n) r = c;
            end
            rem = n - {64'd0, r} * {64'd0, r};
            if (rem > {64'd0, r}) r++;
            return r;
        endfunction

        function automatic void note_item(input logic [SW-1:0] d);
            logic signed [CW-1:0] sat [3];
            logic signed [CW-1:0] rx [3];
            logic signed [63:0]   diff [3];
            logic [63:0]          mag;
            logic [127:0]         sq_sum;
            logic [63:0]          geo_rng;
            logic [127:0]         quo;
            logic [127:0]         rem;
            logic signed [CW-1:0] offset;
            logic [CW-2:0]        range;
            logic signed [65:0]   res;
            logic signed [65:0]   rmax;
            logic [DW-1:0]        dir [3];
            t_los_row             row;
            sq_sum = 0;
            for (int k = 0; k < 3; k++) begin
                sat[k] = d[k*CW +: CW];
                rx[k]  = d[(k+3)*CW +: CW];
                diff[k] = 64'(sat[k]) - 64'(rx[k]);
                mag = diff[k] < 0 ? -diff[k] : diff[k];
                sq_sum += {64'd0, mag} * {64'd0, mag};
            end
            offset = d[6*CW +: CW];
            range  = d[7*CW +: CW-1];
            geo_rng = round_root(sq_sum);
            rmax = (66'sd1 <<< (CW-1)) - 1;
            res = $signed({2'b0, geo_rng}) + 66'(offset) - $signed({26'd0, range});
            row.saturated = 0;
            if (res > rmax) begin
                res = rmax;
                row.saturated = 1;
            end else if (res < -rmax - 1) begin
                res = -rmax - 1;
                row.saturated = 1;
            end
            row.residual = res[CW-1:0];
            row.zero_distance = (geo_rng == 0);
            for (int k = 0; k < 3; k++) begin
                dir[k] = '0;
                if (geo_rng != 0) begin
                    mag = diff[k] < 0 ? -diff[k] : diff[k];
                    quo = ({64'd0, mag} << FB) / {64'd0, geo_rng};
                    rem = ({64'd0, mag} << FB) % {64'd0, geo_rng};
                    if (rem >= {64'd0, geo_rng} - rem) quo++;   // round half away from zero
                    dir[k] = diff[k] > 0 ? -quo[DW-1:0] : quo[DW-1:0];
                end
            end
            row.dir_x = dir[0];
            row.dir_y = dir[1];
            row.dir_z = dir[2];
            pending.insert(pending.size(), row);
        endfunction

        task automatic check_row(input logic [MW-1:0] d, input logic [1:0] u);
            t_los_row w;
            if (pending.size() == 0) begin
                report("unexpected result", d[63:0], '0);
                return;
            end
            w = pending.pop_front();
            if (d[0 +: CW] !== w.residual)
                report("residual", 64'(d[0 +: CW]), 64'(w.residual));
            if (d[CW +: DW] !== w.dir_x)
                report("dir_x", 64'(d[CW +: DW]), 64'(w.dir_x));
            if (d[CW+DW +: DW] !== w.dir_y)
                report("dir_y", 64'(d[CW+DW +: DW]), 64'(w.dir_y));
            if (d[CW+2*DW +: DW] !== w.dir_z)
                report("dir_z", 64'(d[CW+2*DW +: DW]), 64'(w.dir_z));
            if (u[0] !== w.zero_distance)
                report("zero_distance", 64'(u[0]), 64'(w.zero_distance));
            if (u[1] !== w.saturated)
                report("saturated", 64'(u[1]), 64'(w.saturated));
        endtask
    endclass

    t_los_scoreboard sb = new();

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample both handshakes at the rising edge; feed the scoreboard and the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_item(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_row(o_m_tdata, o_m_tuser);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || stim_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: stall at the current rate, or hold off fully during the long stretch.
    always @(negedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [CW-1:0] rand_coord();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return v[CW-1:0];                       // full range
            1: return CW'(v[23:0]);                    // near origin
            2: return {1'b0, {(CW-1){1'b1}}};          // max positive
            3: return {1'b1, {(CW-1){1'b0}}};          // max negative
            default: return CW'($signed(v[31:0]));     // orbital-sized
        endcase
    endfunction

    // Present one item and hold it until the block takes it; valid stays up afterwards.
    task automatic send_item(input logic [SW-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [SW-1:0] pack_item(input logic [CW-1:0] s [3],
                                                input logic [CW-1:0] r [3],
                                                input logic [CW-1:0] off,
                                                input logic [CW-2:0] rng);
        logic [SW-1:0] d;
        d = '0;
        for (int k = 0; k < 3; k++) begin
            d[k*CW +: CW] = s[k];
            d[(k+3)*CW +: CW] = r[k];
        end
        d[6*CW +: CW] = off;
        d[7*CW +: CW-1] = rng;
        return d;
    endfunction

    task automatic send_random(input int count);
        logic [CW-1:0] s [3];
        logic [CW-1:0] r [3];
        logic [63:0]   v;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 3; k++) begin
                s[k] = rand_coord();
                r[k] = ($urandom_range(9) == 0) ? s[k] : rand_coord();
            end
            v = {$urandom, $urandom};
            send_item(pack_item(s, r, rand_coord(), v[CW-2:0]));
        end
    endtask

    task automatic send_directed();
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        logic [CW-1:0] s [3];
        logic [CW-1:0] r [3];
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        // coincident positions, with offset and range extremes
        s = '{default: '0}; r = '{default: '0};
        send_item(pack_item(s, r, '0, '0));
        send_item(pack_item(s, r, mn, {(CW-1){1'b1}}));
        s = '{mx, mn, 41'd5}; r = s;
        send_item(pack_item(s, r, mx, '0));
        // widest separation: saturates high
        s = '{mx, mx, mx}; r = '{mn, mn, mn};
        send_item(pack_item(s, r, mx, '0));
        s = '{mn, mn, mn}; r = '{mx, mx, mx};
        send_item(pack_item(s, r, mx, {(CW-1){1'b1}}));
        // saturates low
        s = '{41'd1, 41'd0, 41'd0}; r = '{default: '0};
        send_item(pack_item(s, r, mn, {(CW-1){1'b1}}));
        // single-axis directions, both signs
        for (int k = 0; k < 3; k++) begin
            s = '{default: '0}; r = '{default: '0};
            s[k] = 41'd1000;
            send_item(pack_item(s, r, '0, 40'd1000));
            s[k] = -41'sd7;
            send_item(pack_item(s, r, 41'd3, 40'd1));
        end
        // tie-ish rounding and small diagonals
        s = '{41'd1, 41'd1, 41'd0}; r = '{default: '0};
        send_item(pack_item(s, r, '0, '0));
        s = '{41'd3, -41'sd4, 41'd12}; r = '{default: '0};
        send_item(pack_item(s, r, '0, '0));
        s = '{41'd1, 41'd1, 41'd1}; r = '{-41'sd1, -41'sd1, -41'sd1};
        send_item(pack_item(s, r, -41'sd1, 40'd3));
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n    = 0;
        i_s_tvalid = 0;
        i_s_tdata  = '0;
        i_m_tready = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_directed();
        // phases: no idling, sender idle, receiver stall, both
        send_random(350);
        send_idle_pct = 55;
        send_random(350);
        send_idle_pct = 0;
        recv_stall_pct = 55;
        send_random(350);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        send_random(300);
        // long hold-off on the receiver while the sender keeps offering items
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (STALL_LEN) @(negedge i_clk);
                hold_off = 0;
            end
            send_random(180);
        join
        drain();
        stim_done = 1;
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/prr_pkg.sv
hw/rtl/prr_sqrt.sv
hw/rtl/prr_div.sv
hw/rtl/pseudorange_residual_and_jacobian.sv
tb/sv/testbench.sv
